// ===== rtl/sli_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted list intersection package
// Shared constants, command codes and status types of the intersection unit.
// ----------------------------------------------------------------------------
package sli_pkg;

    localparam int MAX_LEN = 64;
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int VAL_W   = 32;
    localparam int OP_W    = 2;

    // Command queue between the front and back parts.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef logic [OP_W-1:0] t_op;

    localparam t_op OP_LOAD_A = 2'd0;
    localparam t_op OP_LOAD_B = 2'd1;
    localparam t_op OP_RUN    = 2'd2;

    typedef enum logic [1:0] {
        CMD_LOAD_A = 2'd0,
        CMD_LOAD_B = 2'd1,
        CMD_RUN    = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind               kind;
        logic signed [VAL_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic             walking;
        logic [CNT_W-1:0] cnt_a;
        logic [CNT_W-1:0] cnt_b;
    } t_back_stat;

endpackage

// ===== rtl/sli_if.sv =====
// ----------------------------------------------------------------------------
// Sorted list intersection channels
// Valid/ready interfaces for the item input and the result output.
// ----------------------------------------------------------------------------
interface sli_item_if;
    import sli_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface sli_res_if;
    import sli_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] common_value;
    logic                    last;
    logic                    empty_res;
    logic                    overflow;

    modport source (output valid, output common_value, output last,
                    output empty_res, output overflow, input ready);
    modport sink   (input valid, input common_value, input last,
                    input empty_res, input overflow, output ready);
endinterface

// ===== rtl/sli_front.sv =====
// ----------------------------------------------------------------------------
// Intersection front end
// Accepts items, turns them into commands and holds them in a short queue.
// ----------------------------------------------------------------------------
module sli_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sli_item_if.sink      i_item,
    output sli_pkg::t_cmd o_cmd,
    output logic          o_cmd_valid,
    input  logic          i_cmd_pop
);
    import sli_pkg::*;

    t_cmd               r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0] r_fill, n_fill;

    logic      accept;
    logic      keep;
    logic      push;
    logic      pop;
    t_cmd_kind kind;

    assign i_item.ready = (r_fill != Q_CNT_W'(Q_DEPTH));
    assign accept       = i_item.valid && i_item.ready;

    // An undefined op is taken and discarded here.
    always_comb begin
        keep = 1'b1;
        kind = CMD_LOAD_A;
        unique case (i_item.op)
            OP_LOAD_A: kind = CMD_LOAD_A;
            OP_LOAD_B: kind = CMD_LOAD_B;
            OP_RUN:    kind = CMD_RUN;
            default:   keep = 1'b0;
        endcase
    end

    assign push        = accept && keep;
    assign o_cmd_valid = (r_fill != '0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_fill   = r_fill;
        if (push && !pop) begin
            n_fill = r_fill + 1'b1;
        end else if (pop && !push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= '{kind: kind, value: i_item.value};
        end
    end

endmodule

// ===== rtl/sli_back.sv =====
// ----------------------------------------------------------------------------
// Intersection back end
// Holds both lists and performs the two-pointer walk, each step a read state then a compare state.
// ----------------------------------------------------------------------------
module sli_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sli_pkg::t_cmd      i_cmd,
    input  logic               i_cmd_valid,
    output logic               o_cmd_pop,
    sli_res_if.source          o_res,
    output sli_pkg::t_back_stat o_stat
);
    import sli_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_CMP   = 4'b0100,
        ST_FLUSH = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [VAL_W-1:0] r_mem_a [MAX_LEN];
    logic [VAL_W-1:0] r_mem_b [MAX_LEN];
    logic signed [VAL_W-1:0] r_rd_a, r_rd_b;

    logic [CNT_W-1:0] r_cnt_a, n_cnt_a;
    logic [CNT_W-1:0] r_cnt_b, n_cnt_b;
    logic [CNT_W-1:0] r_idx_a, n_idx_a;
    logic [CNT_W-1:0] r_idx_b, n_idx_b;
    logic             r_drop, n_drop;

    logic signed [VAL_W-1:0] r_pend_val, n_pend_val;
    logic                    r_have_pend, n_have_pend;

    logic                    r_out_valid, n_out_valid;
    logic signed [VAL_W-1:0] r_out_val;
    logic                    r_out_last, r_out_empty, r_out_ovf;

    logic                    we_a, we_b;
    logic                    slot_free;
    logic                    emit;
    logic signed [VAL_W-1:0] emit_val;
    logic                    emit_last, emit_empty;
    logic                    step;

    assign slot_free = !r_out_valid || o_res.ready;

    always_comb begin
        n_state     = r_state;
        n_cnt_a     = r_cnt_a;
        n_cnt_b     = r_cnt_b;
        n_idx_a     = r_idx_a;
        n_idx_b     = r_idx_b;
        n_drop      = r_drop;
        n_pend_val  = r_pend_val;
        n_have_pend = r_have_pend;
        o_cmd_pop   = 1'b0;
        we_a        = 1'b0;
        we_b        = 1'b0;
        emit        = 1'b0;
        emit_val    = r_pend_val;
        emit_last   = 1'b0;
        emit_empty  = 1'b0;
        step        = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.kind)
                        CMD_LOAD_A: begin
                            if (r_cnt_a < CNT_W'(MAX_LEN)) begin
                                we_a    = 1'b1;
                                n_cnt_a = r_cnt_a + 1'b1;
                            end else begin
                                n_drop = 1'b1;
                            end
                        end
                        CMD_LOAD_B: begin
                            if (r_cnt_b < CNT_W'(MAX_LEN)) begin
                                we_b    = 1'b1;
                                n_cnt_b = r_cnt_b + 1'b1;
                            end else begin
                                n_drop = 1'b1;
                            end
                        end
                        CMD_RUN: begin
                            n_idx_a     = '0;
                            n_idx_b     = '0;
                            n_have_pend = 1'b0;
                            if (r_cnt_a == '0 || r_cnt_b == '0) begin
                                n_state = ST_FLUSH;
                            end else begin
                                n_state = ST_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                // A match is held back one step so that the final one can
                // carry the last marker.
                priority if (r_rd_a < r_rd_b) begin
                    n_idx_a = r_idx_a + 1'b1;
                    step    = 1'b1;
                end else if (r_rd_a > r_rd_b) begin
                    n_idx_b = r_idx_b + 1'b1;
                    step    = 1'b1;
                end else if (!r_have_pend || slot_free) begin
                    emit        = r_have_pend;
                    n_pend_val  = r_rd_a;
                    n_have_pend = 1'b1;
                    n_idx_a     = r_idx_a + 1'b1;
                    n_idx_b     = r_idx_b + 1'b1;
                    step        = 1'b1;
                end else begin
                    step = 1'b0;
                end
                if (step) begin
                    if (n_idx_a >= r_cnt_a || n_idx_b >= r_cnt_b) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_FLUSH: begin
                if (slot_free) begin
                    emit       = 1'b1;
                    emit_last  = 1'b1;
                    emit_empty = !r_have_pend;
                    emit_val   = r_have_pend ? r_pend_val : '0;
                    n_cnt_a    = '0;
                    n_cnt_b    = '0;
                    n_drop     = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (emit) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_drop      <= 1'b0;
            r_have_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt_a     <= n_cnt_a;
            r_cnt_b     <= n_cnt_b;
            r_drop      <= n_drop;
            r_have_pend <= n_have_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx_a    <= n_idx_a;
        r_idx_b    <= n_idx_b;
        r_pend_val <= n_pend_val;
        if (emit) begin
            r_out_val   <= emit_val;
            r_out_last  <= emit_last;
            r_out_empty <= emit_empty;
            r_out_ovf   <= r_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_a) begin
            r_mem_a[r_cnt_a[IDX_W-1:0]] <= i_cmd.value;
        end
        r_rd_a <= r_mem_a[r_idx_a[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (we_b) begin
            r_mem_b[r_cnt_b[IDX_W-1:0]] <= i_cmd.value;
        end
        r_rd_b <= r_mem_b[r_idx_b[IDX_W-1:0]];
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.common_value = r_out_val;
    assign o_res.last         = r_out_last;
    assign o_res.empty_res    = r_out_empty;
    assign o_res.overflow     = r_out_ovf;

    assign o_stat.walking = (r_state == ST_READ) || (r_state == ST_CMP);
    assign o_stat.cnt_a   = r_cnt_a;
    assign o_stat.cnt_b   = r_cnt_b;

endmodule

// ===== rtl/sorted_list_intersection_unit.sv =====
// ----------------------------------------------------------------------------
// Sorted list intersection unit
// Loads two ascending lists of signed values and emits their common values.
// ----------------------------------------------------------------------------
// Each input transaction carries an op and a value: op 0 appends the value to
// list A, op 1 appends it to list B, op 2 runs the intersection and op 3 is
// taken and ignored. Each list holds up to 64 values; a push to a full list is
// dropped and sets an overflow flag that is reported on every result of the
// next run. A run walks both lists with two pointers and emits every common
// value once per matching pair, in walk order, with last set on the final
// result; if nothing matches it emits a single result with empty_res set and
// a zero value. After a run both lists and the flag are cleared. Loads stream
// at one per cycle while no run is busy and the queue has room. Each pointer
// step of a run takes a read state (both list memories are registered reads)
// and then a compare state, which may stall while a result waits at the
// output; a flush state delivers the final result. A four-deep command queue
// lets items keep arriving while a run is busy or a result waits at the
// output.
module sorted_list_intersection_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sli_item_if.sink  i_item,
    sli_res_if.source o_res
);
    import sli_pkg::*;

    t_cmd       cmd;
    logic       cmd_valid;
    logic       cmd_pop;
    t_back_stat back_stat;

    // Front part: takes transactions while its queue has room, drops undefined
    // ops and queues the rest as commands.
    sli_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    // Back part: owns the list memories and the walk, and drives the
    // registered result output.
    sli_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .o_res       (o_res),
        .o_stat      (back_stat)
    );

    // An empty result always closes its run and carries a zero value.
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.empty_res |-> o_res.last && (o_res.common_value == '0))
        else $error("empty result without last marker or with non-zero value");

    // The fill counts never pass the list capacity.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (back_stat.cnt_a <= CNT_W'(MAX_LEN)) && (back_stat.cnt_b <= CNT_W'(MAX_LEN)))
        else $error("list fill count beyond capacity");

    // The walk only runs over two non-empty lists.
    a_walk_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_stat.walking |-> (back_stat.cnt_a != '0) && (back_stat.cnt_b != '0))
        else $error("walk started on an empty list");

endmodule
